FILE: design/ftlr_pkg.sv
// Shared types and constants of the fine tile layer renderer.
`default_nettype none

package ftlr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [8:0] SCREEN_WIDTH_RESET  = 9'd320;
    localparam logic [7:0] SCREEN_HEIGHT_RESET = 8'd224;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    localparam logic [6:0]  COL_ORIGIN     = 7'd16;
    localparam logic [5:0]  ROW_ORIGIN     = 6'd4;
    localparam logic [13:0] TILE_MIN_CODE  = 14'h10;
    localparam logic [7:0]  PIX_CLEAR      = 8'hFF;
    localparam logic [3:0]  PIX_LAST_INDEX = 4'hF;

    typedef struct packed {
        logic        mode;
        logic [17:0] load_address;
        logic [7:0]  load_data;
        logic [12:0] map_index;
        logic [15:0] tile_attribute;
    } ftlr_in_t;

    typedef struct packed {
        logic [8:0] pixel_x;
        logic [7:0] pixel_y;
        logic [8:0] pixel_color;
        logic       write_enable;
        logic       last;
    } ftlr_out_t;

    typedef struct packed {
        logic load_we;
        logic capture;
        logic issue_pix;
        logic issue_empty;
    } ftlr_cmd_t;

    typedef struct packed {
        logic is_render;
        logic cull;
        logic can_issue;
        logic last_pix;
    } ftlr_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIXELS,
        ST_EMPTY
    } ftlr_state_t;

endpackage

`default_nettype wire

FILE: design/ftlr_ctrl.sv
// Controller state machine: accepts beats and sequences the pixel reads of a tile.
`default_nettype none

module ftlr_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire ftlr_pkg::ftlr_status_t status,
    output ftlr_pkg::ftlr_cmd_t        cmd
);
    import ftlr_pkg::*;

    ftlr_state_t state_reg;
    ftlr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.is_render) begin
                    state_next = status.cull ? ST_EMPTY : ST_PIXELS;
                end
            end
            ST_PIXELS: begin
                if (status.can_issue && status.last_pix) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (status.can_issue) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = aresetn;
                cmd.load_we = s_valid && aresetn && !status.is_render;
                cmd.capture = s_valid && aresetn && status.is_render;
            end
            ST_PIXELS: begin
                cmd.issue_pix = status.can_issue;
            end
            ST_EMPTY: begin
                cmd.issue_empty = status.can_issue;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/ftlr_datapath.sv
// Datapath: graphics memory, tile position and clipping, read pipeline and output register.
`default_nettype none

module ftlr_datapath #(
    parameter int GRAPHICS_BYTES = 262144,
    parameter int MAP_COLUMNS    = 128,
    parameter int MAP_ROWS       = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire ftlr_pkg::ftlr_in_t                    s_data,
    input  wire logic                                  cfg_valid,
    input  wire logic [ftlr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [ftlr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire ftlr_pkg::ftlr_cmd_t                   cmd,
    output ftlr_pkg::ftlr_status_t                     status,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output ftlr_pkg::ftlr_out_t                        m_data
);
    import ftlr_pkg::*;

    localparam int          AW       = $clog2(GRAPHICS_BYTES);
    localparam logic [18:0] GfxLimit = 19'(GRAPHICS_BYTES);
    localparam logic [7:0]  MapCols  = 8'(MAP_COLUMNS);
    localparam logic [6:0]  MapRows  = 7'(MAP_ROWS);

    logic [7:0] gfx_mem [GRAPHICS_BYTES];

    logic [8:0]  width_reg;
    logic [7:0]  height_reg;
    logic [8:0]  sx_reg;
    logic [7:0]  sy_reg;
    logic [3:0]  flip_reg;
    logic [13:0] code_reg;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;

    logic        b_valid_reg;
    logic        b_valid_next;
    logic [8:0]  b_x_reg;
    logic [7:0]  b_y_reg;
    logic        b_clip_reg;
    logic        b_oob_reg;
    logic        b_empty_reg;
    logic        b_last_reg;
    logic [7:0]  rd_data_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    ftlr_out_t   out_reg;
    ftlr_out_t   out_next;

    logic [6:0]  in_col;
    logic [5:0]  in_row;
    logic [13:0] in_code;
    logic [8:0]  in_sx;
    logic [7:0]  in_sy;
    logic [3:0]  in_flip;
    logic        in_cull;

    logic [8:0]  pix_x;
    logic [7:0]  pix_y;
    logic [17:0] pix_addr;
    logic        pix_oob;
    logic        pix_clip;
    logic [7:0]  pix_byte;
    logic        advance;
    logic        issue;

    assign in_col  = s_data.map_index[6:0];
    assign in_row  = s_data.map_index[12:7];
    assign in_code = s_data.tile_attribute[13:0];
    assign in_sx   = {7'(in_col - COL_ORIGIN), 2'b00};
    assign in_sy   = {6'(in_row - ROW_ORIGIN), 2'b00};
    assign in_flip = {{2{s_data.tile_attribute[15]}}, {2{s_data.tile_attribute[14]}}};

    // Tiles that start left of or above the screen are always culled, so the
    // screen position of a drawn tile is never negative.
    assign in_cull = (in_col < COL_ORIGIN) || (in_row < ROW_ORIGIN)
                  || ({1'b0, in_col} >= MapCols) || ({1'b0, in_row} >= MapRows)
                  || (in_sx >= width_reg) || (in_sy >= height_reg)
                  || (in_code < TILE_MIN_CODE);

    assign advance = !out_valid_reg || m_ready;
    assign issue   = cmd.issue_pix || cmd.issue_empty;

    assign pix_x    = sx_reg + {7'd0, cnt_reg[1:0]};
    assign pix_y    = sy_reg + {6'd0, cnt_reg[3:2]};
    assign pix_addr = {code_reg, cnt_reg ^ flip_reg};
    assign pix_oob  = {1'b0, pix_addr} >= GfxLimit;
    assign pix_clip = (pix_x >= width_reg) || (pix_y >= height_reg);

    assign status.is_render = (s_data.mode == MODE_RENDER);
    assign status.cull      = in_cull;
    assign status.can_issue = advance;
    assign status.last_pix  = (cnt_reg == PIX_LAST_INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SCREEN_WIDTH) begin
                width_reg <= cfg_data;
            end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
                height_reg <= cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_we && ({1'b0, s_data.load_address} < GfxLimit)) begin
            gfx_mem[s_data.load_address[AW-1:0]] <= s_data.load_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue_pix) begin
            rd_data_reg <= gfx_mem[pix_addr[AW-1:0]];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.capture) begin
            cnt_next = '0;
        end else if (cmd.issue_pix) begin
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sx_reg   <= in_sx;
            sy_reg   <= in_sy;
            flip_reg <= in_flip;
            code_reg <= in_code;
        end
        cnt_reg <= cnt_next;
    end

    always_comb begin
        pix_byte = b_oob_reg ? PIX_CLEAR : rd_data_reg;
        out_next = '0;
        out_next.last = b_last_reg;
        if (!b_empty_reg && !b_clip_reg) begin
            out_next.pixel_x      = b_x_reg;
            out_next.pixel_y      = b_y_reg;
            out_next.pixel_color  = {1'b1, pix_byte};
            out_next.write_enable = (pix_byte != PIX_CLEAR);
        end
    end

    always_comb begin
        b_valid_next   = b_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            b_valid_next   = issue;
            out_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            b_x_reg     <= pix_x;
            b_y_reg     <= pix_y;
            b_clip_reg  <= pix_clip;
            b_oob_reg   <= pix_oob;
            b_empty_reg <= cmd.issue_empty;
            b_last_reg  <= cmd.issue_empty || (cnt_reg == PIX_LAST_INDEX);
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

FILE: design/fine_tile_layer_renderer.sv
// Top level of the fine tile layer renderer: controller plus datapath.
//
// The s_ channel carries one beat per item. A load beat (mode 0) writes one
// byte of the graphics memory and produces no result. A render beat (mode 1)
// draws one 4x4 tile from the map position and tile attribute. A culled tile
// produces one empty beat with last set; a drawn tile produces 16 pixel beats
// in raster order, the last one with last set. The m_ channel holds each
// result beat in an output register until it is taken; while m_ready is low
// the read pipeline stops with up to two beats held, and s_ready stays low
// until the tile in progress has issued all its reads. A drawn tile occupies
// the input side while it is accepted and while it issues its 16 pixel reads,
// since the graphics memory has one read port and each pixel is one byte. The
// first result passes through the read stage register and the output register
// before it shows on m_valid. Reset clears the controller, the pipeline valid
// flags and restores the screen size registers to 320 by 224; s_ready and
// cfg_ready are low while reset is asserted. The graphics memory is not
// cleared. The cfg_ channel writes screen width (index 0) or height (index 1);
// it is ready whenever reset is released. The user must write it only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module fine_tile_layer_renderer #(
    parameter int GRAPHICS_BYTES = 262144,
    parameter int MAP_COLUMNS    = 128,
    parameter int MAP_ROWS       = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire ftlr_pkg::ftlr_in_t               s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output ftlr_pkg::ftlr_out_t                   m_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ftlr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ftlr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ftlr_pkg::*;

    ftlr_cmd_t    cmd;
    ftlr_status_t status;

    assign cfg_ready = aresetn;

    ftlr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ftlr_datapath #(
        .GRAPHICS_BYTES (GRAPHICS_BYTES),
        .MAP_COLUMNS    (MAP_COLUMNS),
        .MAP_ROWS       (MAP_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

FILE: design/ftlr_checker.sv
// Port-level checker of the fine tile layer renderer and its bind.
`default_nettype none

module ftlr_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire ftlr_pkg::ftlr_out_t m_data
);
    import ftlr_pkg::*;

    // A stalled result beat must hold.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // A written pixel is an opaque palette entry.
    a_we_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.write_enable |->
            m_data.pixel_color[8] && (m_data.pixel_color[7:0] != PIX_CLEAR))
        else $error("write enable on transparent or zero color");

    // Clipped and empty beats carry no position.
    a_clip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.pixel_color == 9'd0) |->
            (m_data.pixel_x == 9'd0) && (m_data.pixel_y == 8'd0) && !m_data.write_enable)
        else $error("clipped beat carries a position");

endmodule

bind fine_tile_layer_renderer ftlr_checker u_ftlr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the fine tile layer renderer, with its own pixel predictor.
module tb;
    import ftlr_pkg::*;

    localparam int GRAPHICS_BYTES = 262144;
    localparam int MAP_COLUMNS    = 128;
    localparam int MAP_ROWS       = 64;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    ftlr_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    ftlr_out_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic [7:0]  graphics_mirror [int];
    logic [13:0] tile_codes [$];
    ftlr_out_t   expected_beats [$];
    ftlr_out_t   want;
    int          scr_width  = 320;
    int          scr_height = 224;
    bit          gaps_on = 1'b1;
    int          ready_hold = 0;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          loads_sent = 0;
    int          renders_sent = 0;
    int          culled_count = 0;
    int          beats_checked = 0;
    int          screens_set = 0;

    fine_tile_layer_renderer #(
        .GRAPHICS_BYTES(GRAPHICS_BYTES),
        .MAP_COLUMNS(MAP_COLUMNS),
        .MAP_ROWS(MAP_ROWS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[fine_tile_layer_renderer] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold--;
            m_ready <= 1'b0;
        end else if (gaps_on) begin
            m_ready <= ($urandom_range(0, 99) >= 38);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, int expected_value, int actual_value);
        if (expected_value != actual_value) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected_value, actual_value);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, m_data);
                mismatches++;
            end else begin
                want = expected_beats.pop_front();
                check_field("pixel_x", want.pixel_x, m_data.pixel_x);
                check_field("pixel_y", want.pixel_y, m_data.pixel_y);
                check_field("pixel_color", want.pixel_color, m_data.pixel_color);
                check_field("write_enable", want.write_enable, m_data.write_enable);
                check_field("last", want.last, m_data.last);
                beats_checked++;
            end
        end
    end

    function automatic void predict_tile(ftlr_in_t item);
        int          col;
        int          row;
        int          sx;
        int          sy;
        int          x;
        int          y;
        logic [13:0] code;
        logic [3:0]  flip_mask;
        logic [17:0] addr;
        logic [7:0]  pix;
        ftlr_out_t   beat;
        col  = item.map_index[6:0];
        row  = item.map_index[12:7];
        sx   = col * 4 - 64;
        sy   = row * 4 - 16;
        code = item.tile_attribute[13:0];
        if (col >= MAP_COLUMNS || row >= MAP_ROWS || sx >= scr_width || sx < -3 ||
            sy >= scr_height || sy < -3 || code < TILE_MIN_CODE) begin
            beat = '0;
            beat.last = 1'b1;
            expected_beats.push_back(beat);
            culled_count++;
            return;
        end
        flip_mask = {{2{item.tile_attribute[15]}}, {2{item.tile_attribute[14]}}};
        for (int k = 0; k < 16; k++) begin
            x = sx + k % 4;
            y = sy + k / 4;
            beat = '0;
            if (x >= 0 && x < scr_width && y >= 0 && y < scr_height) begin
                addr = {code, 4'(k) ^ flip_mask};
                if (addr < GRAPHICS_BYTES && graphics_mirror.exists(addr)) begin
                    pix = graphics_mirror[addr];
                end else begin
                    pix = PIX_CLEAR;
                end
                if (addr < GRAPHICS_BYTES && !graphics_mirror.exists(addr)) begin
                    $display("%0t: stimulus reads unwritten graphics byte %h", $time, addr);
                    mismatches++;
                end
                beat.pixel_x      = 9'(x);
                beat.pixel_y      = 8'(y);
                beat.pixel_color  = {1'b1, pix};
                beat.write_enable = (pix != PIX_CLEAR);
            end
            beat.last = (k == 15);
            expected_beats.push_back(beat);
        end
    endfunction

    function automatic void apply_item(ftlr_in_t item);
        items_sent++;
        if (item.mode == MODE_LOAD) begin
            if (item.load_address < GRAPHICS_BYTES) begin
                graphics_mirror[item.load_address] = item.load_data;
            end
            loads_sent++;
        end else begin
            renders_sent++;
            predict_tile(item);
        end
    endfunction

    function automatic ftlr_in_t load_beat(logic [17:0] addr, logic [7:0] data);
        ftlr_in_t item;
        item.mode           = MODE_LOAD;
        item.load_address   = addr;
        item.load_data      = data;
        item.map_index      = $urandom;
        item.tile_attribute = $urandom;
        return item;
    endfunction

    function automatic ftlr_in_t render_beat(logic [12:0] idx, logic [15:0] attr);
        ftlr_in_t item;
        item.mode           = MODE_RENDER;
        item.load_address   = $urandom;
        item.load_data      = $urandom;
        item.map_index      = idx;
        item.tile_attribute = attr;
        return item;
    endfunction

    function automatic logic [12:0] map_pos(int col, int row);
        return {6'(row), 7'(col)};
    endfunction

    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 99) < 20) begin
            return PIX_CLEAR;
        end
        return 8'($urandom);
    endfunction

    function automatic ftlr_in_t random_render();
        int          pick;
        int          col;
        int          row;
        int          edge_col;
        int          edge_row;
        logic [15:0] attr;
        pick     = $urandom_range(0, 99);
        edge_col = 16 + (scr_width - 1) / 4;
        edge_row = 4 + (scr_height - 1) / 4;
        if (pick < 60) begin
            col = $urandom_range(16, edge_col);
            row = $urandom_range(4, edge_row);
        end else if (pick < 75) begin
            col = $urandom_range(0, 1) ? edge_col : $urandom_range(16, edge_col);
            row = $urandom_range(0, 1) ? edge_row : $urandom_range(4, edge_row);
        end else begin
            col = $urandom_range(0, MAP_COLUMNS - 1);
            row = $urandom_range(0, MAP_ROWS - 1);
        end
        attr[15:14] = 2'($urandom);
        if ($urandom_range(0, 99) < 85) begin
            attr[13:0] = tile_codes[$urandom_range(0, tile_codes.size() - 1)];
        end else begin
            attr[13:0] = 14'($urandom_range(0, 15));
        end
        return render_beat(map_pos(col, row), attr);
    endfunction

    task automatic send_item(input ftlr_in_t item);
        while (gaps_on && $urandom_range(0, 99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_item(item);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_screen(input int width, input int height);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= 9'(width);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        scr_width = width;
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= 9'(height);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        scr_height = height;
        cfg_valid <= 1'b0;
        screens_set++;
    endtask

    task automatic load_tile(input logic [13:0] code);
        for (int i = 0; i < 16; i++) begin
            send_item(load_beat({code, 4'(i)}, random_byte()));
        end
        tile_codes.push_back(code);
    endtask

    task automatic test_load_tiles();
        send_item(load_beat(18'h00000, 8'hA5));
        for (int i = 0; i < 16; i++) begin
            send_item(load_beat({14'd16, 4'(i)}, 8'(i * 17)));
        end
        tile_codes.push_back(14'd16);
        load_tile(14'h3FFF);
    endtask

    task automatic test_reset_screen();
        send_item(render_beat(map_pos(16, 4), 16'h0010));
        send_item(render_beat(map_pos(95, 59), 16'h0010));
        send_item(render_beat(map_pos(96, 59), 16'h0010));
        send_item(render_beat(map_pos(95, 60), 16'h0010));
    endtask

    task automatic test_culling();
        send_item(render_beat(map_pos(16, 4), 16'h000F));
        send_item(render_beat(13'h0000, 16'h0000));
        send_item(render_beat(map_pos(15, 10), 16'h0010));
        send_item(render_beat(map_pos(20, 3), 16'h0010));
    endtask

    task automatic test_flips();
        for (int f = 0; f < 4; f++) begin
            send_item(render_beat(map_pos(30, 20), {2'(f), 14'd16}));
        end
    endtask

    task automatic test_extremes();
        wait_drained();
        set_screen(448, 240);
        send_item(render_beat(13'h1FFF, 16'hFFFF));
        send_item(render_beat(map_pos(127, 63), 16'h4010));
        send_item(render_beat(map_pos(16, 4), 16'h8010));
    endtask

    task automatic test_clipping();
        wait_drained();
        set_screen(322, 223);
        send_item(render_beat(map_pos(96, 59), 16'h0010));
        send_item(render_beat(map_pos(96, 20), 16'hC010));
        send_item(render_beat(map_pos(40, 59), 16'h3FFF));
        wait_drained();
        set_screen(1, 1);
        send_item(render_beat(map_pos(16, 4), 16'hBFFF));
        send_item(render_beat(map_pos(17, 4), 16'h0010));
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_screen(320, 224);
        gaps_on    = 1'b0;
        ready_hold = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) begin
            send_item(random_render());
        end
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic random_phase(input int count);
        int          first;
        int          pick;
        logic [13:0] code;
        first = items_sent;
        while (items_sent - first < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                code = tile_codes[$urandom_range(0, tile_codes.size() - 1)];
                send_item(load_beat({code, 4'($urandom)}, random_byte()));
            end else if (pick < 15) begin
                send_item(load_beat(18'($urandom), random_byte()));
            end else if (pick < 18 && tile_codes.size() < 10) begin
                load_tile(14'($urandom_range(16, 16'h3FFF)));
            end else begin
                send_item(random_render());
            end
        end
    endtask

    task automatic test_random();
        int phase_width [5];
        int phase_height [5];
        phase_width  = '{1, 448, $urandom_range(1, 448), $urandom_range(1, 448), 320};
        phase_height = '{1, 240, $urandom_range(1, 240), $urandom_range(1, 240), 224};
        for (int p = 0; p < 5; p++) begin
            wait_drained();
            set_screen(phase_width[p], phase_height[p]);
            gaps_on = (p != 2);
            random_phase(18);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_tiles();
        test_reset_screen();
        test_culling();
        test_flips();
        test_extremes();
        test_clipping();
        test_backpressure();
        test_random();
        wait_drained();
        $display("Checked %0d pixel beats from %0d render items (%0d culled) and %0d loads,",
                 beats_checked, renders_sent, culled_count, loads_sent);
        $display("across %0d screen sizes, with flips, clipping, random gaps and a long stall.",
                 screens_set);
        if (mismatches == 0) begin
            $display("[fine_tile_layer_renderer] OK");
        end else begin
            $display("[fine_tile_layer_renderer] ERROR");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/ftlr_pkg.sv
design/ftlr_ctrl.sv
design/ftlr_datapath.sv
design/fine_tile_layer_renderer.sv
design/ftlr_checker.sv
test/tb.sv
